// ===== hw/rtl/vpg_pkg.sv =====
// Shared types and constants of the video pixel generator.
package vpg_pkg;

  // Address and memory sizes.
  localparam int unsigned AddrW        = 13;
  localparam int unsigned VideoBytes   = 8192;
  localparam int unsigned FontBytes    = 768;
  localparam int unsigned FontBanks    = 3;
  localparam int unsigned FontBankDepth = FontBytes / FontBanks;

  // Drawable areas of the bitmap and text modes.
  localparam int unsigned BitmapArea   = 'h2000;
  localparam int unsigned TextFullArea = 'h1500;
  localparam int unsigned TextBigArea  = 'h540;

  // Display mode codes.
  localparam logic [7:0] ModeMono    = 8'd0;
  localparam logic [7:0] ModeColor   = 8'd1;
  localparam logic [7:0] ModeText    = 8'd2;
  localparam logic [7:0] ModeTextBig = 8'd3;

  // Input kind carried on tuser.
  localparam logic CmdVideo = 1'b0;
  localparam logic CmdFont  = 1'b1;

  // Job queue depth; a power of two so the pointers wrap by themselves.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCountW    = $clog2(QueueDepth + 1);

  // Index of the final pixel of each job kind.
  localparam logic [4:0] LastMono  = 5'd7;
  localparam logic [4:0] LastColor = 5'd1;
  localparam logic [4:0] LastGlyph = 5'd23;

  typedef enum logic [1:0] {
    JOB_MONO,
    JOB_COLOR,
    JOB_TEXT,
    JOB_TEXT_BIG
  } job_kind_t;

  // One drawing job: base position, colour byte and pixel bits.
  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  x0;
    logic [7:0]  y0;
    logic [7:0]  colours;
    logic [23:0] rows;
  } job_t;

  // Final pixel index of a job kind.
  function automatic logic [4:0] last_index(job_kind_t kind);
    logic [4:0] idx;
    unique case (kind)
      JOB_MONO:  idx = LastMono;
      JOB_COLOR: idx = LastColor;
      default:   idx = LastGlyph;
    endcase
    return idx;
  endfunction

endpackage

// ===== hw/rtl/vpg_ram.sv =====
// Generic single write port RAM with a registered read port.
module vpg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/vpg_front.sv =====
// Front end: accepts input beats, loads the font, classifies video bytes into jobs.
module vpg_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        display_mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [12:0]       in_address,
  input  logic [7:0]        in_data,
  output logic              q_push,
  input  logic              q_ready,
  output vpg_pkg::job_t     q_job
);

  logic                 accept;
  logic [12:0]          even;
  logic                 in_video;
  logic                 job_en;
  logic                 hold_en;
  logic                 font_rd;
  logic                 font_we;
  vpg_pkg::job_t        job;
  logic [19:0]          div_prod;
  logic [7:0]           font_idx;
  logic [9:0]           font_rem;
  logic [1:0]           font_bank;
  logic [7:0]           held_character;
  logic                 s1_valid;
  vpg_pkg::job_t        s1_job;
  logic [7:0]           font_rows [vpg_pkg::FontBanks];

  assign in_ready = !s1_valid || q_ready;
  assign accept   = in_valid && in_ready;
  assign even     = {in_address[12:1], 1'b0};
  assign in_video = {1'b0, in_address} < 14'(vpg_pkg::VideoBytes);

  // Font byte index split into bank (index mod 3) and row (index div 3).
  // The reciprocal 683/2048 is exact for indexes below 1536.
  assign div_prod  = in_address[9:0] * 10'd683;
  assign font_idx  = div_prod[18:11];
  assign font_rem  = in_address[9:0] - ({1'b0, font_idx, 1'b0} + {2'b00, font_idx});
  assign font_bank = font_rem[1:0];
  assign font_we   = accept && (in_cmd == vpg_pkg::CmdFont) &&
                     ({1'b0, in_address} < 14'(vpg_pkg::FontBytes));

  // Classify a video byte by the display mode.
  always_comb begin
    job_en       = 1'b0;
    hold_en      = 1'b0;
    job.kind     = vpg_pkg::JOB_MONO;
    job.x0       = {in_address[4:0], 3'b000};
    job.y0       = in_address[12:5];
    job.colours  = in_data;
    job.rows     = {in_data, 16'h0000};
    if ((in_cmd == vpg_pkg::CmdVideo) && in_video) begin
      unique case (display_mode)
        vpg_pkg::ModeMono: begin
          job_en = {1'b0, in_address} < 14'(vpg_pkg::BitmapArea);
        end
        vpg_pkg::ModeColor: begin
          job_en   = {1'b0, in_address} < 14'(vpg_pkg::BitmapArea);
          job.kind = vpg_pkg::JOB_COLOR;
          job.x0   = {in_address[5:0], 1'b0};
          job.y0   = {1'b0, in_address[12:6]};
        end
        vpg_pkg::ModeText: begin
          job.kind = vpg_pkg::JOB_TEXT;
          job.x0   = {even[6:0], 1'b0};
          job.y0   = 8'({2'b00, even[12:7]} * 8'd6);
          if ({1'b0, even} < 14'(vpg_pkg::TextFullArea)) begin
            job_en  = in_address[0];
            hold_en = !in_address[0];
          end
        end
        vpg_pkg::ModeTextBig: begin
          job.kind = vpg_pkg::JOB_TEXT_BIG;
          job.x0   = {1'b0, even[5:0], 1'b0};
          job.y0   = 8'({1'b0, even[12:6]} * 8'd6);
          if ({1'b0, even} < 14'(vpg_pkg::TextBigArea)) begin
            job_en  = in_address[0];
            hold_en = !in_address[0];
          end
        end
        default: begin
          job_en = 1'b0;
        end
      endcase
    end
  end

  // Glyph rows are read when the colour byte is taken, so later font loads
  // cannot reach a glyph already in flight.
  assign font_rd = accept && job_en &&
                   ((job.kind == vpg_pkg::JOB_TEXT) || (job.kind == vpg_pkg::JOB_TEXT_BIG));

  // Font store, one bank per glyph row byte.
  for (genvar g = 0; g < vpg_pkg::FontBanks; g++) begin : g_font
    vpg_ram #(
      .WIDTH(8),
      .DEPTH(vpg_pkg::FontBankDepth)
    ) u_font_bank (
      .clk     (clk),
      .wr_en   (font_we && (font_bank == 2'(g))),
      .wr_addr (font_idx),
      .wr_data (in_data),
      .rd_en   (font_rd),
      .rd_addr (held_character),
      .rd_data (font_rows[g])
    );
  end

  // Held character code.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_character <= 8'h00;
    end else if (accept && hold_en) begin
      held_character <= in_data;
    end
  end

  // Stage between classification and the queue, aligned with the font read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= job_en;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_job <= job;
    end
  end

  // Job pushed to the queue, with the glyph rows filled in for text jobs.
  assign q_push = s1_valid && q_ready;
  always_comb begin
    q_job = s1_job;
    if ((s1_job.kind == vpg_pkg::JOB_TEXT) || (s1_job.kind == vpg_pkg::JOB_TEXT_BIG)) begin
      q_job.rows = {font_rows[0], font_rows[1], font_rows[2]};
    end
  end

endmodule

// ===== hw/rtl/vpg_queue.sv =====
// Short job queue between the front end and the pixel sequencer.
module vpg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          push_ready,
  input  vpg_pkg::job_t push_job,
  input  logic          pop,
  output logic          pop_valid,
  output vpg_pkg::job_t pop_job
);

  vpg_pkg::job_t                 entries [vpg_pkg::QueueDepth];
  logic [vpg_pkg::QPtrW-1:0]     wr_ptr;
  logic [vpg_pkg::QPtrW-1:0]     rd_ptr;
  logic [vpg_pkg::QCountW-1:0]   count;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = count != vpg_pkg::QCountW'(vpg_pkg::QueueDepth);
  assign pop_valid  = count != '0;
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= vpg_pkg::QCountW'(vpg_pkg::QueueDepth))
    else $error("job queue count above depth");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("job queue lost a pushed entry");
`endif

endmodule

// ===== hw/rtl/vpg_back.sv =====
// Back end: steps through each job and issues one pixel beat per cycle while the output is not stalled.
module vpg_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  vpg_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_x,
  output logic [7:0]    out_y,
  output logic          out_big,
  output logic          out_mono,
  output logic [3:0]    out_colour,
  output logic          out_last
);

  vpg_pkg::job_t job;
  logic          job_valid;
  logic [4:0]    k;
  logic [23:0]   bits;
  logic          advance;
  logic          emit;
  logic          is_last;
  logic [7:0]    xoff;
  logic [7:0]    yoff;
  logic [7:0]    px;
  logic [7:0]    py;
  logic [3:0]    pcolour;
  logic          pbig;

  assign advance = !out_valid || out_ready;
  assign emit    = job_valid && advance;
  assign is_last = k == vpg_pkg::last_index(job.kind);
  assign q_pop   = q_valid && (!job_valid || (emit && is_last));

  // Pixel of the current step.
  always_comb begin
    unique case (job.kind)
      vpg_pkg::JOB_MONO: begin
        xoff    = {5'b00000, k[2:0]};
        yoff    = 8'h00;
        pcolour = {3'b000, bits[23]};
      end
      vpg_pkg::JOB_COLOR: begin
        xoff    = {7'b0000000, k[0]};
        yoff    = 8'h00;
        pcolour = k[0] ? job.colours[3:0] : job.colours[7:4];
      end
      default: begin
        xoff    = {6'b000000, k[1:0]};
        yoff    = {5'b00000, k[4:2]};
        pcolour = bits[23] ? job.colours[3:0] : job.colours[7:4];
      end
    endcase
    pbig = (job.kind == vpg_pkg::JOB_COLOR) || (job.kind == vpg_pkg::JOB_TEXT_BIG);
    px   = job.x0 + xoff;
    py   = job.y0 + yoff;
    if (job.kind == vpg_pkg::JOB_TEXT_BIG) begin
      px[7] = 1'b0;
      py[7] = 1'b0;
    end
  end

  // Job register and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      k         <= 5'd0;
    end else if (q_pop) begin
      job_valid <= 1'b1;
      k         <= 5'd0;
    end else if (emit && is_last) begin
      job_valid <= 1'b0;
    end else if (emit) begin
      k <= k + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job  <= q_job;
      bits <= q_job.rows;
    end else if (emit) begin
      bits <= {bits[22:0], 1'b0};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x      <= px;
      out_y      <= py;
      out_big    <= pbig;
      out_mono   <= job.kind == vpg_pkg::JOB_MONO;
      out_colour <= pcolour;
      out_last   <= is_last;
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (k <= vpg_pkg::last_index(job.kind)))
    else $error("pixel step beyond end of job");

  a_job_continues: assert property (@(posedge clk) disable iff (rst)
    (emit && !is_last) |=> (job_valid && (k == $past(k) + 5'd1)))
    else $error("job dropped before its last pixel");
`endif

endmodule

// ===== hw/rtl/video_pixel_generator.sv =====
// Video pixel generator top level: mode register, front end, job queue, pixel sequencer.
//
// Input stream (s_axis_*): one beat per video memory byte or font byte. tuser
// selects a font load (1) or a video byte (0); tdata carries address and byte.
// Output stream (m_axis_*): one beat per pixel write; tdata carries position
// and colour, tuser the big and mono flags, tlast the last pixel of an input beat.
// The mode register is written through cfg_wr_en/cfg_wr_data; the user must write
// it only while idle, which the block itself does not enforce. With the queue and
// sequencer empty, an input beat passes the front-end stage, a queue entry and the job
// register before the output register presents its first pixel.
// Throughput: the pixel sequencer issues one pixel per cycle while the receiver is
// ready; an input beat makes 8 pixels in mono bitmap mode, 2 in colour bitmap mode and
// 24 for a text colour byte; font loads and character codes make none and bypass it.
// A four-entry job queue lets the input keep flowing while the sequencer works.
// Reset clears the mode to mono bitmap, the held character, the queue and the
// output register. The font store is not cleared and must be loaded before
// text is drawn. When the receiver stalls, the output beat holds, the queue
// fills and then s_axis_tready drops.
module video_pixel_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,     // display_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // address[12:0], data_byte[20:13], zero pad
  input  logic        s_axis_tuser,    // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // pixel_x[7:0], pixel_y[15:8], colour[19:16], zero pad
  output logic [1:0]  m_axis_tuser,    // big[0], mono[1]
  output logic        m_axis_tlast     // last
);

  logic [7:0]    display_mode;
  logic          q_push;
  logic          q_ready;
  vpg_pkg::job_t push_job;
  logic          q_pop;
  logic          q_valid;
  vpg_pkg::job_t pop_job;
  logic [7:0]    pixel_x;
  logic [7:0]    pixel_y;
  logic          big;
  logic          mono;
  logic [3:0]    colour;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= vpg_pkg::ModeMono;
    end else if (cfg_wr_en) begin
      display_mode <= cfg_wr_data;
    end
  end

  vpg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .display_mode (display_mode),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_cmd       (s_axis_tuser),
    .in_address   (s_axis_tdata[12:0]),
    .in_data      (s_axis_tdata[20:13]),
    .q_push       (q_push),
    .q_ready      (q_ready),
    .q_job        (push_job)
  );

  vpg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_ready),
    .push_job   (push_job),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_job    (pop_job)
  );

  vpg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_x      (pixel_x),
    .out_y      (pixel_y),
    .out_big    (big),
    .out_mono   (mono),
    .out_colour (colour),
    .out_last   (m_axis_tlast)
  );

  // Pack the pixel fields, lowest field first.
  assign m_axis_tdata = {4'h0, colour, pixel_y, pixel_x};
  assign m_axis_tuser = {mono, big};

endmodule

// ===== dv/vpg_checker.sv =====
// Checker for the video pixel generator: predicts pixel beats from input beats and compares them.
module vpg_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // address[12:0], data_byte[20:13], zero pad
  input  logic        s_axis_tuser,    // cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,    // pixel_x[7:0], pixel_y[15:8], colour[19:16], zero pad
  input  logic [1:0]  m_axis_tuser,    // big[0], mono[1]
  input  logic        m_axis_tlast,    // last
  output int unsigned mismatches,
  output int unsigned pending
);

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic       big;
    logic       mono;
    logic [3:0] colour;
    logic       last;
  } pixel_t;

  // Shadow copy of the block's state.
  logic [7:0] mode_shadow;
  logic [7:0] held_char;
  logic [7:0] font_copy [vpg_pkg::FontBytes];

  pixel_t      expected_pixels [$];
  int unsigned error_count = 0;
  int unsigned queued = 0;

  assign mismatches = error_count;
  assign pending    = queued;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic push_pixel(input int x, input int y, input logic big, input logic mono,
                            input logic [3:0] colour, input logic last);
    pixel_t p;
    p.x      = x[7:0];
    p.y      = y[7:0];
    p.big    = big;
    p.mono   = mono;
    p.colour = colour;
    p.last   = last;
    expected_pixels.push_back(p);
  endtask

  // A 4x6 glyph of the held character, row by row, leftmost pixel from the top bit.
  task automatic draw_glyph(input int x0, input int y0, input logic big,
                            input logic [7:0] colours, input logic [7:0] wrap);
    logic [23:0] rows;
    logic [3:0]  c;
    int          base;
    int          k;
    base = held_char * 3;
    rows = {font_copy[base], font_copy[base + 1], font_copy[base + 2]};
    k = 0;
    for (int j = 0; j < 6; j++) begin
      for (int i = 0; i < 4; i++) begin
        c = rows[23] ? colours[3:0] : colours[7:4];
        push_pixel((x0 + i) & wrap, (y0 + j) & wrap, big, 1'b0, c, k == 23);
        k++;
        rows = rows << 1;
      end
    end
  endtask

  // Works out the pixels caused by one input beat and updates the shadow state.
  task automatic predict_pixels(input logic cmd, input logic [12:0] addr,
                                input logic [7:0] data);
    logic [12:0] even;
    even = {addr[12:1], 1'b0};
    if (cmd == vpg_pkg::CmdFont) begin
      if (addr < vpg_pkg::FontBytes) font_copy[addr] = data;
      return;
    end
    if (addr >= vpg_pkg::VideoBytes) return;
    case (mode_shadow)
      vpg_pkg::ModeMono: begin
        if (addr < vpg_pkg::BitmapArea) begin
          for (int j = 0; j < 8; j++)
            push_pixel((addr % 32) * 8 + j, addr / 32, 1'b0, 1'b1, {3'b0, data[7 - j]},
                       j == 7);
        end
      end
      vpg_pkg::ModeColor: begin
        if (addr < vpg_pkg::BitmapArea) begin
          push_pixel((addr % 64) * 2, (addr / 64) & 127, 1'b1, 1'b0, data[7:4], 1'b0);
          push_pixel((addr % 64) * 2 + 1, (addr / 64) & 127, 1'b1, 1'b0, data[3:0], 1'b1);
        end
      end
      vpg_pkg::ModeText: begin
        if (even < vpg_pkg::TextFullArea) begin
          if (!addr[0]) held_char = data;
          else draw_glyph((even * 2) % 256, ((even * 2) / 256) * 6, 1'b0, data, 8'hFF);
        end
      end
      vpg_pkg::ModeTextBig: begin
        if (even < vpg_pkg::TextBigArea) begin
          if (!addr[0]) held_char = data;
          else draw_glyph((even * 2) % 128, ((even * 2) / 128) * 6, 1'b1, data, 8'h7F);
        end
      end
      default: ;
    endcase
  endtask

  // Compares one output beat with the oldest expected pixel.
  task automatic check_pixel();
    pixel_t got;
    pixel_t want;
    got.x      = m_axis_tdata[7:0];
    got.y      = m_axis_tdata[15:8];
    got.big    = m_axis_tuser[0];
    got.mono   = m_axis_tuser[1];
    got.colour = m_axis_tdata[19:16];
    got.last   = m_axis_tlast;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf({"unexpected pixel x=%0d y=%0d big=%0b mono=%0b ",
                                 "colour=%0d last=%0b"},
                                got.x, got.y, got.big, got.mono, got.colour, got.last));
      return;
    end
    want = expected_pixels.pop_front();
    if (got !== want)
      report_mismatch($sformatf({"pixel x=%0d/%0d y=%0d/%0d big=%0b/%0b mono=%0b/%0b ",
                                 "colour=%0d/%0d last=%0b/%0b (got/expected)"},
                                got.x, want.x, got.y, want.y, got.big, want.big,
                                got.mono, want.mono, got.colour, want.colour,
                                got.last, want.last));
  endtask

  // Output beats are checked before new input beats are predicted in the same cycle.
  always @(posedge clk) begin
    if (rst) begin
      mode_shadow = vpg_pkg::ModeMono;
      held_char   = 8'd0;
      expected_pixels.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_pixel();
      if (cfg_wr_en) mode_shadow = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready)
        predict_pixels(s_axis_tuser, s_axis_tdata[12:0], s_axis_tdata[20:13]);
    end
    queued = expected_pixels.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the video pixel generator: stimulus, stalls, watchdog and verdict.
module tb_top;

  // Cycles without any accepted beat before the run is abandoned.
  localparam int unsigned QuietLimit = 1000;
  // Character codes 0 up to this count minus one carry loaded glyphs, and so does 255.
  localparam int unsigned GlyphChars = 32;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned quiet_cycles;
  bit          calm;

  video_pixel_generator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  vpg_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sends one input beat, sometimes after an idle burst; returns at the falling edge
  // after acceptance with tvalid still high.
  task automatic send_beat(input logic cmd, input logic [12:0] addr, input logic [7:0] data);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b0, data, addr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes the mode register once the block has drained and settled.
  task automatic set_mode(input logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // A character code followed by its colour pair inside the given text area.
  task automatic send_text_pair(input int area);
    logic [12:0] even;
    even = 13'($urandom_range(0, area - 1)) & 13'h1FFE;
    send_beat(vpg_pkg::CmdVideo, even, 8'($urandom_range(0, GlyphChars - 1)));
    send_beat(vpg_pkg::CmdVideo, even + 13'd1, 8'($urandom_range(0, 255)));
  endtask

  // Random traffic in one mode: mostly well-formed beats, some font reloads and noise.
  task automatic random_phase(input logic [7:0] mode, input int count);
    int          sent;
    int          pick;
    logic [12:0] addr;
    logic [7:0]  data;
    set_mode(mode);
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        if ($urandom_range(0, 3) != 0)
          send_beat(vpg_pkg::CmdFont, 13'($urandom_range(0, vpg_pkg::FontBytes - 1)),
                    8'($urandom_range(0, 255)));
        else
          send_beat(vpg_pkg::CmdFont,
                    13'($urandom_range(vpg_pkg::FontBytes, vpg_pkg::VideoBytes - 1)),
                    8'($urandom_range(0, 255)));
        sent++;
      end else if (pick < 18 || mode > vpg_pkg::ModeTextBig || mode < vpg_pkg::ModeText) begin
        addr = 13'($urandom_range(0, vpg_pkg::VideoBytes - 1));
        data = 8'($urandom_range(0, 255));
        // A character code in a text mode stays among the loaded glyphs.
        if ((mode == vpg_pkg::ModeText || mode == vpg_pkg::ModeTextBig) && !addr[0])
          data = data & 8'(GlyphChars - 1);
        send_beat(vpg_pkg::CmdVideo, addr, data);
        sent++;
      end else begin
        send_text_pair(mode == vpg_pkg::ModeText ? vpg_pkg::TextFullArea
                                                 : vpg_pkg::TextBigArea);
        sent += 2;
      end
    end
  endtask

  // Receiver: ready drops in random bursts until the calm stretch at the end.
  initial begin
    int gap;
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 13);
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which no beat is accepted on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [7:0] glyph_byte;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 24'd0;
    s_axis_tuser  = vpg_pkg::CmdVideo;
    calm          = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Load the glyphs in use: character 0 blank, character 255 solid, the rest random.
    for (int i = 0; i < 3 * GlyphChars; i++) begin
      if (i < 3) glyph_byte = 8'h00;
      else glyph_byte = 8'($urandom_range(0, 255));
      send_beat(vpg_pkg::CmdFont, 13'(i), glyph_byte);
    end
    for (int i = 0; i < 3; i++)
      send_beat(vpg_pkg::CmdFont, 13'(vpg_pkg::FontBytes - 3 + i), 8'hFF);

    // Directed: mono bitmap corners and bit patterns.
    send_beat(vpg_pkg::CmdVideo, 13'h0000, 8'hFF);
    send_beat(vpg_pkg::CmdVideo, 13'h1FFF, 8'hA5);
    send_beat(vpg_pkg::CmdVideo, 13'h0020, 8'h00);

    // Directed: colour bitmap nibbles at both ends of memory and one in between.
    set_mode(vpg_pkg::ModeColor);
    send_beat(vpg_pkg::CmdVideo, 13'h0000, 8'hF0);
    send_beat(vpg_pkg::CmdVideo, 13'h1FFF, 8'h0F);
    send_beat(vpg_pkg::CmdVideo, 13'h1040, 8'h5A);

    // Directed text: a colour pair before any character code uses the reset character,
    // the last cell of the area, and bytes past the area that must not be held.
    set_mode(vpg_pkg::ModeText);
    send_beat(vpg_pkg::CmdVideo, 13'h0001, 8'h1E);
    send_beat(vpg_pkg::CmdVideo, 13'h14FE, 8'hFF);
    send_beat(vpg_pkg::CmdVideo, 13'h14FF, 8'h0F);
    send_beat(vpg_pkg::CmdVideo, 13'h1500, 8'h07);
    send_beat(vpg_pkg::CmdVideo, 13'h1501, 8'h3C);
    send_beat(vpg_pkg::CmdVideo, 13'h14FF, 8'hA5);

    // Directed doubled text: last cell, out of area, and a colour byte for the first cell.
    set_mode(vpg_pkg::ModeTextBig);
    send_beat(vpg_pkg::CmdVideo, 13'h053E, 8'h00);
    send_beat(vpg_pkg::CmdVideo, 13'h053F, 8'hF0);
    send_beat(vpg_pkg::CmdVideo, 13'h0540, 8'h01);
    send_beat(vpg_pkg::CmdVideo, 13'h0541, 8'h12);
    send_beat(vpg_pkg::CmdVideo, 13'h0001, 8'h34);

    // Directed: modes above text draw nothing; font loads out of range are dropped.
    set_mode(vpg_pkg::ModeTextBig + 8'd1);
    send_beat(vpg_pkg::CmdVideo, 13'h0010, 8'h55);
    send_beat(vpg_pkg::CmdVideo, 13'h0011, 8'h66);
    send_beat(vpg_pkg::CmdFont, 13'(vpg_pkg::FontBytes), 8'h12);
    send_beat(vpg_pkg::CmdFont, 13'h1FFF, 8'h34);
    set_mode(8'hFF);
    send_beat(vpg_pkg::CmdVideo, 13'h0000, 8'h12);
    send_beat(vpg_pkg::CmdVideo, 13'h0001, 8'h34);

    // Random phases across all modes.
    random_phase(vpg_pkg::ModeMono, 25);
    random_phase(vpg_pkg::ModeColor, 25);
    random_phase(vpg_pkg::ModeText, 35);
    random_phase(vpg_pkg::ModeTextBig, 35);
    random_phase(8'($urandom_range(vpg_pkg::ModeTextBig + 1, 255)), 12);
    random_phase(vpg_pkg::ModeColor, 20);
    random_phase(vpg_pkg::ModeMono, 20);
    random_phase(vpg_pkg::ModeTextBig, 25);
    calm = 1'b1;
    random_phase(vpg_pkg::ModeText, 30);

    // Drain and let the pipeline settle before the verdict.
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
